/* rtl/core/heat_grid_separable_blur_defines.svh */
// ----------------------------------------------------------------------------
// heat grid separable blur: assertion macros
// shared concurrent assertion forms for the rtl modules of the heat grid
// ----------------------------------------------------------------------------
`ifndef HEAT_GRID_SEPARABLE_BLUR_DEFINES_SVH
`define HEAT_GRID_SEPARABLE_BLUR_DEFINES_SVH

// same-cycle implication
`define HGSB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HGSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/hgsb_pkg.sv */
// ----------------------------------------------------------------------------
// hgsb_pkg
// widths, codes, constants and shared types of the heat grid blur block
// ----------------------------------------------------------------------------
package hgsb_pkg;

   localparam int HEAT_W     = 27;
   localparam int TEXEL_W    = 13;
   localparam int MEAN_W     = 15;
   localparam int FUNC_W     = 2;
   localparam int COORD_W    = 5;
   localparam int KERN_SUM_W = HEAT_W + 5;
   localparam int KERN_SHIFT = 5;

   typedef logic [HEAT_W-1:0] heat_type;

   localparam heat_type HEAT_HALF = HEAT_W'(2048);
   localparam heat_type HEAT_ONE  = HEAT_W'(4096);
   localparam heat_type HEAT_MAX  = HEAT_W'(134217727);
   localparam heat_type BLUR_CAP  = HEAT_W'(16384);

   localparam logic [KERN_SUM_W-1:0] KERN_ROUND = KERN_SUM_W'(16);
   localparam logic [MEAN_W-1:0]     MEAN_RESET = MEAN_W'(2048);

   localparam logic [FUNC_W-1:0] FUNC_DEPOSIT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_BLUR    = 2'd2;

   typedef struct packed {
      logic shift;
      logic emit;
   } tap_ctl_type;

endpackage

/* rtl/core/heat_grid_separable_blur.sv */
// ----------------------------------------------------------------------------
// heat_grid_separable_blur
// heat grid in memory with deposit, read and a separable five tap blur pass
// ----------------------------------------------------------------------------
// usage
//   a request is taken at a rising edge with start high and busy low.
//   req_func selects deposit, read or blur; func 3 reads. one response per
//   request, shown for exactly one cycle with rsp_valid high; the receiver
//   cannot stall, so it must take every response in that cycle.
//   deposit and read: the memory is read at the request edge, then the
//   update state registers the value and, on a deposit, writes back the
//   same entry; rsp_valid follows from the response register, and a new
//   request is taken once the update state has returned to idle.
//   blur: a row sweep and a column sweep through the single read port of
//   each memory, a drain after each, a reciprocal multiply for the mean,
//   then a read of the addressed cell, after which rsp_valid rises.
//   after reset the grid is swept to 0.5, one cell a cycle, with busy
//   high; the mean reads 0.5.
// ----------------------------------------------------------------------------
`include "heat_grid_separable_blur_defines.svh"

module heat_grid_separable_blur
   import hgsb_pkg::*;
#(
   parameter int GRID_WIDTH  = 32,
   parameter int GRID_HEIGHT = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [COORD_W-1:0]       req_cell_x,
   input  logic [COORD_W-1:0]       req_cell_y,
   input  logic signed [HEAT_W-1:0] req_heat_delta,
   output logic                     rsp_valid,
   output logic [HEAT_W-1:0]        rsp_heat_value,
   output logic [TEXEL_W-1:0]       rsp_texel_level,
   output logic [MEAN_W-1:0]        rsp_average_heat
);

   localparam int CELLS   = GRID_WIDTH * GRID_HEIGHT;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int X_W     = $clog2(GRID_WIDTH);
   localparam int Y_W     = $clog2(GRID_HEIGHT);
   localparam int MAX_LEN = (GRID_WIDTH > GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT;
   localparam int K_W     = $clog2(MAX_LEN + 4);
   localparam int O_W     = $clog2(MAX_LEN);
   localparam int TOT_W   = ADDR_W + 15;

   localparam logic [K_W-1:0]    ROW_LAST_K = K_W'(GRID_WIDTH + 3);
   localparam logic [K_W-1:0]    COL_LAST_K = K_W'(GRID_HEIGHT + 3);
   localparam logic [K_W-1:0]    X_LAST_K   = K_W'(GRID_WIDTH - 1);
   localparam logic [K_W-1:0]    Y_LAST_K   = K_W'(GRID_HEIGHT - 1);
   localparam logic [K_W-1:0]    LEAD_K     = K_W'(2);
   localparam logic [K_W-1:0]    EMIT_K     = K_W'(4);
   localparam logic [O_W-1:0]    LAST_ROW   = O_W'(GRID_HEIGHT - 1);
   localparam logic [O_W-1:0]    LAST_COL   = O_W'(GRID_WIDTH - 1);
   localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
   localparam logic [TOT_W-1:0]  HALF_CELLS = TOT_W'(CELLS / 2);
   localparam logic [1:0]        DRAIN_LAST = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_ROW,
      ST_DRAIN_ROW,
      ST_COL,
      ST_DRAIN_COL,
      ST_DIVIDE,
      ST_FETCH
   } state_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [X_W-1:0] x,
                                                   input logic [Y_W-1:0] y);
      cell_addr = ADDR_W'(32'(y) * 32'(GRID_WIDTH) + 32'(x));
   endfunction

   // storage
   heat_type heat_mem [CELLS];
   heat_type row_mem  [CELLS];
   heat_type heat_rd_ff;
   heat_type row_rd_ff;

   // control
   state_type          state_ff;
   state_type          state_in;
   logic [K_W-1:0]     k_ff;
   logic [K_W-1:0]     k_in;
   logic [O_W-1:0]     o_ff;
   logic [O_W-1:0]     o_in;
   logic [1:0]         drain_ff;
   logic [1:0]         drain_in;
   logic [ADDR_W-1:0]  clr_ff;
   logic [ADDR_W-1:0]  clr_in;
   logic [MEAN_W-1:0]  mean_ff;
   logic [MEAN_W-1:0]  mean_in;
   logic               rpt_ff;
   logic               rpt_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   tap_ctl_type        tap_ctl_ff;
   tap_ctl_type        tap_ctl_in;

   // payload
   logic [FUNC_W-1:0]  func_ff;
   logic [FUNC_W-1:0]  func_in;
   logic [ADDR_W-1:0]  addr_ff;
   logic [ADDR_W-1:0]  addr_in;
   heat_type           delta_ff;
   heat_type           delta_in;
   heat_type           val_ff;
   heat_type           val_in;
   logic [TOT_W-1:0]   tot_ff;
   logic [TOT_W-1:0]   tot_in;
   logic               tap_col_ff;
   logic               tap_col_in;
   logic [ADDR_W-1:0]  tap_dest_ff;
   logic [ADDR_W-1:0]  tap_dest_in;
   logic               col1_ff;
   logic [ADDR_W-1:0]  dest1_ff;
   logic               col2_ff;
   logic [ADDR_W-1:0]  dest2_ff;
   heat_type           rsp_heat_ff;
   heat_type           rsp_heat_in;
   logic [TEXEL_W-1:0] rsp_texel_ff;
   logic [TEXEL_W-1:0] rsp_texel_in;
   logic [MEAN_W-1:0]  rsp_avg_ff;
   logic [MEAN_W-1:0]  rsp_avg_in;

   // datapath
   logic                    accept;
   logic [X_W-1:0]          req_x;
   logic [Y_W-1:0]          req_y;
   logic [K_W-1:0]          tap_pos;
   logic [K_W-1:0]          tap_lim;
   logic [K_W-1:0]          tap_clip;
   logic [K_W-1:0]          emit_pos;
   logic [ADDR_W-1:0]       rd_addr;
   logic signed [HEAT_W+1:0] dep_sum;
   heat_type                dep_val;
   heat_type                kern_data;
   logic                    kern_valid;
   heat_type                kern_res;
   heat_type                col_cap;
   logic                    heat_we;
   logic [ADDR_W-1:0]       heat_wa;
   heat_type                heat_wd;
   logic                    row_we;
   logic [TEXEL_W-1:0]      tex_clamp;
   logic [2*TEXEL_W-1:0]    tex_sq;
   logic                    div_start;
   logic                    div_busy;
   logic                    div_done;
   logic [TOT_W-1:0]        div_quo;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      req_x = (32'(req_cell_x) > 32'(GRID_WIDTH - 1)) ? X_W'(GRID_WIDTH - 1)
                                                     : X_W'(req_cell_x);
      req_y = (32'(req_cell_y) > 32'(GRID_HEIGHT - 1)) ? Y_W'(GRID_HEIGHT - 1)
                                                      : Y_W'(req_cell_y);

      // edge replicated tap position along the sweep
      tap_pos  = (k_ff < LEAD_K) ? '0 : k_ff - LEAD_K;
      tap_lim  = (state_ff == ST_COL) ? Y_LAST_K : X_LAST_K;
      tap_clip = (tap_pos > tap_lim) ? tap_lim : tap_pos;
      emit_pos = k_ff - EMIT_K;

      case (state_ff)
         ST_IDLE:  rd_addr = cell_addr(req_x, req_y);
         ST_ROW:   rd_addr = cell_addr(tap_clip[X_W-1:0], o_ff[Y_W-1:0]);
         ST_COL:   rd_addr = cell_addr(o_ff[X_W-1:0], tap_clip[Y_W-1:0]);
         default:  rd_addr = addr_ff;
      endcase

      // saturating deposit
      dep_sum = $signed({2'b00, heat_rd_ff}) + $signed({{2{delta_ff[HEAT_W-1]}}, delta_ff});
      if (dep_sum < 0) begin
         dep_val = '0;
      end else if (dep_sum > $signed({2'b00, HEAT_MAX})) begin
         dep_val = HEAT_MAX;
      end else begin
         dep_val = dep_sum[HEAT_W-1:0];
      end

      kern_data = tap_col_ff ? row_rd_ff : heat_rd_ff;
      col_cap   = (kern_res > BLUR_CAP) ? BLUR_CAP : kern_res;

      heat_we = 1'b0;
      heat_wa = addr_ff;
      heat_wd = dep_val;
      if (state_ff == ST_CLEAR) begin
         heat_we = 1'b1;
         heat_wa = clr_ff;
         heat_wd = HEAT_HALF;
      end else if (kern_valid && col2_ff) begin
         heat_we = 1'b1;
         heat_wa = dest2_ff;
         heat_wd = col_cap;
      end else if (state_ff == ST_UPDATE && func_ff == FUNC_DEPOSIT) begin
         heat_we = 1'b1;
      end
      row_we = kern_valid && !col2_ff;

      // texel level from the reported value
      tex_clamp    = (val_ff > HEAT_ONE) ? TEXEL_W'(HEAT_ONE) : val_ff[TEXEL_W-1:0];
      tex_sq       = (2*TEXEL_W)'(tex_clamp) * (2*TEXEL_W)'(tex_clamp)
                   + (2*TEXEL_W)'(2048);
      rsp_texel_in = tex_sq[TEXEL_W+11:12];
      rsp_heat_in  = val_ff;
      rsp_avg_in   = mean_ff;
      rsp_valid_in = rpt_ff;

      div_start = (state_ff == ST_DIVIDE) && !div_busy && !div_done;

      state_in    = state_ff;
      k_in        = k_ff;
      o_in        = o_ff;
      drain_in    = drain_ff;
      clr_in      = clr_ff;
      mean_in     = mean_ff;
      rpt_in      = 1'b0;
      func_in     = func_ff;
      addr_in     = addr_ff;
      delta_in    = delta_ff;
      val_in      = val_ff;
      tot_in      = tot_ff;
      tap_ctl_in  = '0;
      tap_col_in  = 1'b0;
      tap_dest_in = tap_dest_ff;

      if (kern_valid && col2_ff) begin
         tot_in = tot_ff + TOT_W'(col_cap);
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               func_in  = req_func;
               addr_in  = cell_addr(req_x, req_y);
               delta_in = req_heat_delta;
               if (req_func == FUNC_BLUR) begin
                  state_in = ST_ROW;
                  k_in     = '0;
                  o_in     = '0;
                  tot_in   = '0;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            val_in   = (func_ff == FUNC_DEPOSIT) ? dep_val : heat_rd_ff;
            rpt_in   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_ROW: begin
            tap_ctl_in.shift = 1'b1;
            tap_ctl_in.emit  = (k_ff >= EMIT_K);
            tap_dest_in      = cell_addr(emit_pos[X_W-1:0], o_ff[Y_W-1:0]);
            k_in             = k_ff + K_W'(1);
            if (k_ff == ROW_LAST_K) begin
               k_in = '0;
               o_in = o_ff + O_W'(1);
               if (o_ff == LAST_ROW) begin
                  o_in     = '0;
                  drain_in = '0;
                  state_in = ST_DRAIN_ROW;
               end
            end
         end
         ST_DRAIN_ROW: begin
            drain_in = drain_ff + 2'd1;
            if (drain_ff == DRAIN_LAST) begin
               state_in = ST_COL;
            end
         end
         ST_COL: begin
            tap_ctl_in.shift = 1'b1;
            tap_ctl_in.emit  = (k_ff >= EMIT_K);
            tap_col_in       = 1'b1;
            tap_dest_in      = cell_addr(o_ff[X_W-1:0], emit_pos[Y_W-1:0]);
            k_in             = k_ff + K_W'(1);
            if (k_ff == COL_LAST_K) begin
               k_in = '0;
               o_in = o_ff + O_W'(1);
               if (o_ff == LAST_COL) begin
                  o_in     = '0;
                  drain_in = '0;
                  state_in = ST_DRAIN_COL;
               end
            end
         end
         ST_DRAIN_COL: begin
            drain_in = drain_ff + 2'd1;
            if (drain_ff == DRAIN_LAST) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               mean_in  = div_quo[MEAN_W-1:0];
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_UPDATE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         k_ff         <= '0;
         o_ff         <= '0;
         drain_ff     <= '0;
         clr_ff       <= '0;
         mean_ff      <= MEAN_RESET;
         rpt_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tap_ctl_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         o_ff         <= o_in;
         drain_ff     <= drain_in;
         clr_ff       <= clr_in;
         mean_ff      <= mean_in;
         rpt_ff       <= rpt_in;
         rsp_valid_ff <= rsp_valid_in;
         tap_ctl_ff   <= tap_ctl_in;
      end
      func_ff      <= func_in;
      addr_ff      <= addr_in;
      delta_ff     <= delta_in;
      val_ff       <= val_in;
      tot_ff       <= tot_in;
      tap_col_ff   <= tap_col_in;
      tap_dest_ff  <= tap_dest_in;
      col1_ff      <= tap_col_ff;
      dest1_ff     <= tap_dest_ff;
      col2_ff      <= col1_ff;
      dest2_ff     <= dest1_ff;
      rsp_heat_ff  <= rsp_heat_in;
      rsp_texel_ff <= rsp_texel_in;
      rsp_avg_ff   <= rsp_avg_in;
   end

   // heat memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (heat_we) begin
         heat_mem[heat_wa] <= heat_wd;
      end
      heat_rd_ff <= heat_mem[rd_addr];
   end

   // row pass memory
   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[dest2_ff] <= kern_res;
      end
      row_rd_ff <= row_mem[rd_addr];
   end

   hgsb_kernel5 u_kernel (
      .clock     (clock),
      .reset     (reset),
      .tap_ctl   (tap_ctl_ff),
      .tap_data  (kern_data),
      .res_valid (kern_valid),
      .res_data  (kern_res)
   );

   hgsb_mean_div #(
      .DIVISOR    (CELLS),
      .DIVIDEND_W (TOT_W)
   ) u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (tot_ff + HALF_CELLS),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_heat_value   = rsp_heat_ff;
   assign rsp_texel_level  = rsp_texel_ff;
   assign rsp_average_heat = rsp_avg_ff;

   `HGSB_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy low after request")
   `HGSB_ASSERT_NEXT(a_rsp_spacing, clock, reset, rsp_valid, !rsp_valid, "response strobes adjacent")
   `HGSB_ASSERT_IMPLY(a_clear_quiet, clock, reset, state_ff == ST_CLEAR, busy && !rsp_valid, "response or idle during clear")

endmodule

/* rtl/core/hgsb_kernel5.sv */
// ----------------------------------------------------------------------------
// hgsb_kernel5
// five tap sliding window, weights 5 1 20 1 5 over 32, rounded, registered
// ----------------------------------------------------------------------------
module hgsb_kernel5
   import hgsb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  tap_ctl_type tap_ctl,
   input  heat_type    tap_data,
   output logic        res_valid,
   output heat_type    res_data
);

   heat_type                win_ff [5];
   heat_type                win_in [5];
   logic                    emit_ff;
   logic                    emit_in;
   logic                    valid_ff;
   logic                    valid_in;
   heat_type                res_ff;
   heat_type                res_in;
   logic [KERN_SUM_W-1:0]   sum;
   logic [KERN_SUM_W-1:0]   rnd;

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         win_in[i] = win_ff[i];
      end
      if (tap_ctl.shift) begin
         for (int i = 0; i < 4; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[4] = tap_data;
      end
      emit_in = tap_ctl.shift && tap_ctl.emit;

      sum = ({5'b0, win_ff[0]} << 2) + {5'b0, win_ff[0]}
          + {5'b0, win_ff[1]}
          + ({5'b0, win_ff[2]} << 4) + ({5'b0, win_ff[2]} << 2)
          + {5'b0, win_ff[3]}
          + ({5'b0, win_ff[4]} << 2) + {5'b0, win_ff[4]};
      rnd      = sum + KERN_ROUND;
      res_in   = rnd[KERN_SUM_W-1:KERN_SHIFT];
      valid_in = emit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         emit_ff  <= emit_in;
         valid_ff <= valid_in;
      end
      for (int i = 0; i < 5; i++) begin
         win_ff[i] <= win_in[i];
      end
      res_ff <= res_in;
   end

   assign res_valid = valid_ff;
   assign res_data  = res_ff;

endmodule

/* rtl/core/hgsb_mean_div.sv */
// ----------------------------------------------------------------------------
// hgsb_mean_div
// division by a fixed cell count: reciprocal multiply, then one correction
// ----------------------------------------------------------------------------
module hgsb_mean_div #(
   parameter int DIVISOR    = 1024,
   parameter int DIVIDEND_W = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   output logic                  busy,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam longint RECIP   = (longint'(1) <<< DIVIDEND_W) / longint'(DIVISOR);
   localparam int     RECIP_W = $clog2(RECIP + 1);
   localparam int     PROD_W  = DIVIDEND_W + RECIP_W;
   localparam logic [RECIP_W-1:0]    RECIP_C = RECIP_W'(RECIP);
   localparam logic [DIVIDEND_W-1:0] DIV_C   = DIVIDEND_W'(DIVISOR);

   logic [DIVIDEND_W-1:0] num_ff;
   logic [DIVIDEND_W-1:0] num_in;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVIDEND_W-1:0] quo_in;
   logic                  phase_ff;
   logic                  phase_in;
   logic                  busy_ff;
   logic                  busy_in;
   logic                  done_ff;
   logic                  done_in;
   logic [PROD_W-1:0]     prod;
   logic [DIVIDEND_W-1:0] back;
   logic [DIVIDEND_W-1:0] rem;

   always_comb begin
      num_in   = num_ff;
      quo_in   = quo_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;

      // estimate is the quotient or one below it
      prod = PROD_W'(num_ff) * PROD_W'(RECIP_C);
      back = quo_ff * DIV_C;
      rem  = num_ff - back;

      if (busy_ff) begin
         if (!phase_ff) begin
            quo_in   = DIVIDEND_W'(prod[PROD_W-1:DIVIDEND_W]);
            phase_in = 1'b1;
         end else begin
            if (rem >= DIV_C) begin
               quo_in = quo_ff + DIVIDEND_W'(1);
            end
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         num_in   = dividend;
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
